>>> rtl/sjlm_pkg.sv
// ----------------------------------------------------------------------------
// sjlm_pkg
// Shared types and constants of the servo joint limit and PWM mux block.
// ----------------------------------------------------------------------------
`default_nettype none

package sjlm_pkg;

  localparam int ANGLE_W = 16;
  localparam int PULSE_W = 10;
  localparam int LINE_W  = 3;
  localparam int JOINT_W = 5;

  // Read fields of a rejected read.
  localparam logic signed [ANGLE_W-1:0] BAD_READ = 16'sh8000;

  typedef enum logic [2:0] {
    MODE_SET_ANGLE  = 3'd0,
    MODE_SET_OFFSET = 3'd1,
    MODE_SET_LOW    = 3'd2,
    MODE_SET_HIGH   = 3'd3,
    MODE_SET_HOME   = 3'd4,
    MODE_READ       = 3'd5,
    MODE_TICK       = 3'd6,
    MODE_RESTORE    = 3'd7
  } mode_t;

  // Factory home angle of each joint, tenths of a degree.
  function automatic logic signed [ANGLE_W-1:0] default_home(input logic [JOINT_W-1:0] j);
    logic signed [ANGLE_W-1:0] h;
    case (j)
      5'd0:    h = -16'sd40;
      5'd1:    h = 16'sd245;
      5'd2:    h = 16'sd470;
      5'd3:    h = -16'sd100;
      5'd4:    h = -16'sd205;
      5'd5:    h = 16'sd50;
      5'd6:    h = 16'sd445;
      5'd7:    h = 16'sd245;
      5'd8:    h = -16'sd75;
      5'd12:   h = 16'sd15;
      5'd13:   h = -16'sd70;
      5'd14:   h = -16'sd390;
      5'd15:   h = 16'sd250;
      5'd16:   h = 16'sd195;
      5'd17:   h = -16'sd105;
      5'd18:   h = -16'sd510;
      5'd19:   h = -16'sd305;
      5'd20:   h = 16'sd60;
      default: h = 16'sd0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/servo_joint_limit_and_mux_pwm.sv
// ----------------------------------------------------------------------------
// servo_joint_limit_and_mux_pwm
// Per-joint limit/home table and pulse-width store driving a multiplexed
// servo PWM output. Commands set angles, limits and home, read settings,
// restore defaults, or advance the mux tick.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  in       | input     | in_valid/in_stall  | in_mode, in_joint, in_angle
//  out      | output    | out_valid/out_stall| out_ok, out_low_limit, out_high_limit,
//           |           |                    | out_home_angle, out_mux_line,
//           |           |                    | out_pulse_group0..2, out_frame_done
//  cfg      | input     | cfg_wr_en          | cfg_wr_data (clockwise)
//
//  Limit, home and read commands pass through table read, update and result load.
//  Set angle and offset commands step through clamp/scale, reciprocal multiply, fixup.
//  A tick makes one pulse RAM read per group through the single read port.
//  Restore sweeps the table through SWEEP, MAP_Q and MAP_FIX for each joint; the same
//  sweep runs after reset, with in_stall high.
//  A result waits in the output register while out_stall holds; the next word is
//  accepted meanwhile, and finishes when the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_joint_limit_and_mux_pwm #(
  parameter int JOINT_COUNT = 24,
  parameter int MUX_LINES   = 8,
  parameter int ANGLE_LOW   = -800,
  parameter int ANGLE_HIGH  = 800,
  parameter int PULSE_LOW   = 492,
  parameter int PULSE_HIGH  = 816
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_mode,
  input  wire logic [4:0]         in_joint,
  input  wire logic signed [15:0] in_angle,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_ok,
  output logic signed [15:0]      out_low_limit,
  output logic signed [15:0]      out_high_limit,
  output logic signed [15:0]      out_home_angle,
  output logic [2:0]              out_mux_line,
  output logic [9:0]              out_pulse_group0,
  output logic [9:0]              out_pulse_group1,
  output logic [9:0]              out_pulse_group2,
  output logic                    out_frame_done
);

  localparam int AW       = $clog2(JOINT_COUNT);
  localparam int TBL_W    = 3 * sjlm_pkg::ANGLE_W;
  localparam int RECIP_SH = 23;

  localparam logic signed [15:0] AL16 = 16'(ANGLE_LOW);
  localparam logic signed [15:0] AH16 = 16'(ANGLE_HIGH);
  localparam logic signed [16:0] AL17 = 17'(ANGLE_LOW);
  localparam logic [11:0] ASPAN = 12'(ANGLE_HIGH - ANGLE_LOW);
  localparam logic [9:0]  PMAG  = 10'((PULSE_HIGH >= PULSE_LOW) ? (PULSE_HIGH - PULSE_LOW)
                                                                : (PULSE_LOW - PULSE_HIGH));
  localparam logic [9:0]  PL10  = 10'(PULSE_LOW);
  localparam logic [9:0]  PH10  = 10'(PULSE_HIGH);
  localparam logic [23:0] RECIP = 24'((longint'(1) << RECIP_SH) / longint'(ANGLE_HIGH - ANGLE_LOW));
  localparam logic [2:0]  LINE_LAST = 3'(MUX_LINES - 1);
  localparam logic [2:0]  LA_RESET  = 3'(1 % MUX_LINES);
  localparam logic [AW-1:0] JOINT_LAST = AW'(JOINT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_MAP_Q,
    S_MAP_FIX,
    S_TICK,
    S_DONE
  } state_t;

  state_t              state_r;
  sjlm_pkg::mode_t     mode_r;
  logic [4:0]          joint_r;
  logic signed [15:0]  angle_r;
  logic                clockwise_r;
  logic                sweep_r;
  logic                init_r;
  logic                sweep_cw_r;
  logic [AW-1:0]       sidx_r;
  logic [AW-1:0]       map_idx_r;
  logic [21:0]         n_r;
  logic [9:0]          q0_r;
  logic [2:0]          ls_r;
  logic [2:0]          la_r;
  logic [1:0]          tg_r;
  logic                tv_r;

  logic                res_ok_r;
  logic signed [15:0]  res_low_r;
  logic signed [15:0]  res_high_r;
  logic signed [15:0]  res_home_r;
  logic [2:0]          res_mux_r;
  logic [9:0]          res_p0_r;
  logic [9:0]          res_p1_r;
  logic [9:0]          res_p2_r;
  logic                res_frame_r;

  logic                out_valid_r;
  logic                out_ok_r;
  logic signed [15:0]  out_low_r;
  logic signed [15:0]  out_high_r;
  logic signed [15:0]  out_home_r;
  logic [2:0]          out_mux_r;
  logic [9:0]          out_p0_r;
  logic [9:0]          out_p1_r;
  logic [9:0]          out_p2_r;
  logic                out_frame_r;

  // table RAM: {low, high, home}
  logic                tbl_we;
  logic [AW-1:0]       tbl_waddr;
  logic [TBL_W-1:0]    tbl_wdata;
  logic [AW-1:0]       tbl_raddr;
  logic [TBL_W-1:0]    tbl_rdata;
  logic                pw_we;
  logic [AW-1:0]       pw_raddr;
  logic [9:0]          pw_rdata;

  logic signed [15:0]  rd_low;
  logic signed [15:0]  rd_high;
  logic signed [15:0]  rd_home;
  logic                jvalid;
  logic                in_acc;
  logic                out_free;
  logic                out_load;

  logic signed [15:0]  def_home;
  logic signed [16:0]  clamp_a;
  logic signed [16:0]  clamp_lo;
  logic signed [16:0]  clamp_hi;
  logic signed [16:0]  clamp_c;
  logic signed [16:0]  dist17;
  logic [21:0]         n_calc;
  logic [45:0]         recip_prod;
  logic [21:0]         q_span;
  logic [21:0]         rem;
  logic [9:0]          q_fix;
  logic                map_cw;
  logic                map_neg;
  logic [9:0]          pulse_base;
  logic [9:0]          pulse_calc;

  logic                ok_low;
  logic                ok_high;
  logic                ok_home;

  logic [4:0]          tick_idx;
  logic                tick_valid;
  logic [2:0]          ls_nxt;
  logic [2:0]          la_nxt;

  assign rd_low  = tbl_rdata[47:32];
  assign rd_high = tbl_rdata[31:16];
  assign rd_home = tbl_rdata[15:0];
  assign jvalid  = joint_r < 5'(JOINT_COUNT);
  assign in_acc  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;

  assign ok_low  = jvalid && (angle_r < rd_high) && (angle_r >= AL16);
  assign ok_high = jvalid && (angle_r > rd_low) && (angle_r <= AH16);
  assign ok_home = jvalid && (angle_r >= rd_low) && (angle_r <= rd_high);

  assign def_home = sjlm_pkg::default_home(5'(sidx_r));

  // clamp to the limits, then scale the distance from the low bound
  always_comb begin
    if (state_r == S_SWEEP) begin
      clamp_a  = {def_home[15], def_home};
      clamp_lo = 17'(AL16);
      clamp_hi = 17'(AH16);
    end else begin
      if (mode_r == sjlm_pkg::MODE_SET_OFFSET) begin
        clamp_a = {angle_r[15], angle_r} + {rd_home[15], rd_home};
      end else begin
        clamp_a = {angle_r[15], angle_r};
      end
      clamp_lo = {rd_low[15], rd_low};
      clamp_hi = {rd_high[15], rd_high};
    end
    clamp_c = clamp_a;
    if (clamp_c < clamp_lo) begin
      clamp_c = clamp_lo;
    end
    if (clamp_c > clamp_hi) begin
      clamp_c = clamp_hi;
    end
    dist17 = clamp_c - AL17;
    n_calc = {10'b0, dist17[11:0]} * {12'b0, PMAG};
  end

  // n / ASPAN by reciprocal: the estimate is low by at most one
  assign recip_prod = {24'b0, n_r} * {22'b0, RECIP};
  assign q_span     = {12'b0, q0_r} * {10'b0, ASPAN};
  assign rem        = n_r - q_span;
  assign q_fix      = (rem >= {10'b0, ASPAN}) ? (q0_r + 10'd1) : q0_r;
  assign map_cw     = sweep_r ? sweep_cw_r : clockwise_r;
  assign map_neg    = map_cw ? (PULSE_HIGH < PULSE_LOW) : (PULSE_HIGH > PULSE_LOW);
  assign pulse_base = map_cw ? PL10 : PH10;
  assign pulse_calc = map_neg ? (pulse_base - q_fix) : (pulse_base + q_fix);

  assign tick_idx   = 5'(la_r) + 5'(tg_r) * 5'(MUX_LINES);
  assign tick_valid = tick_idx < 5'(JOINT_COUNT);
  assign pw_raddr   = tick_valid ? tick_idx[AW-1:0] : '0;
  assign ls_nxt     = (ls_r == LINE_LAST) ? 3'd0 : (ls_r + 3'd1);
  assign la_nxt     = (la_r == LINE_LAST) ? 3'd0 : (la_r + 3'd1);

  assign tbl_raddr  = (state_r == S_IDLE) ? in_joint[AW-1:0] : joint_r[AW-1:0];
  assign pw_we      = (state_r == S_MAP_FIX);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = joint_r[AW-1:0];
    tbl_wdata = tbl_rdata;
    if (state_r == S_SWEEP) begin
      tbl_we    = 1'b1;
      tbl_waddr = sidx_r;
      tbl_wdata = {AL16, AH16, def_home};
    end else if (state_r == S_EXEC) begin
      case (mode_r)
        sjlm_pkg::MODE_SET_LOW: begin
          tbl_we    = ok_low;
          tbl_wdata = {angle_r, rd_high, rd_home};
        end
        sjlm_pkg::MODE_SET_HIGH: begin
          tbl_we    = ok_high;
          tbl_wdata = {rd_low, angle_r, rd_home};
        end
        sjlm_pkg::MODE_SET_HOME: begin
          tbl_we    = ok_home;
          tbl_wdata = {rd_low, rd_high, angle_r};
        end
        default: tbl_we = 1'b0;
      endcase
    end
  end

  sjlm_ram #(
    .WIDTH (TBL_W),
    .DEPTH (JOINT_COUNT)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  sjlm_ram #(
    .WIDTH (sjlm_pkg::PULSE_W),
    .DEPTH (JOINT_COUNT)
  ) u_pw_ram (
    .clk     (clk),
    .wr_en   (pw_we),
    .wr_addr (map_idx_r),
    .wr_data (pulse_calc),
    .rd_addr (pw_raddr),
    .rd_data (pw_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= 1'b1;
      init_r      <= 1'b1;
      sweep_cw_r  <= 1'b1;
      sidx_r      <= '0;
      clockwise_r <= 1'b1;
      ls_r        <= 3'd0;
      la_r        <= LA_RESET;
      tg_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clockwise_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r      <= sjlm_pkg::mode_t'(in_mode);
            joint_r     <= in_joint;
            angle_r     <= in_angle;
            res_ok_r    <= 1'b0;
            res_low_r   <= '0;
            res_high_r  <= '0;
            res_home_r  <= '0;
            res_mux_r   <= '0;
            res_p0_r    <= '0;
            res_p1_r    <= '0;
            res_p2_r    <= '0;
            res_frame_r <= 1'b0;
            state_r     <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (mode_r)
            sjlm_pkg::MODE_SET_ANGLE, sjlm_pkg::MODE_SET_OFFSET: begin
              if (jvalid) begin
                res_ok_r  <= 1'b1;
                n_r       <= n_calc;
                map_idx_r <= joint_r[AW-1:0];
                state_r   <= S_MAP_Q;
              end else begin
                state_r <= S_DONE;
              end
            end
            sjlm_pkg::MODE_SET_LOW: begin
              res_ok_r <= ok_low;
              state_r  <= S_DONE;
            end
            sjlm_pkg::MODE_SET_HIGH: begin
              res_ok_r <= ok_high;
              state_r  <= S_DONE;
            end
            sjlm_pkg::MODE_SET_HOME: begin
              res_ok_r <= ok_home;
              state_r  <= S_DONE;
            end
            sjlm_pkg::MODE_READ: begin
              res_ok_r   <= jvalid;
              res_low_r  <= jvalid ? rd_low  : sjlm_pkg::BAD_READ;
              res_high_r <= jvalid ? rd_high : sjlm_pkg::BAD_READ;
              res_home_r <= jvalid ? rd_home : sjlm_pkg::BAD_READ;
              state_r    <= S_DONE;
            end
            sjlm_pkg::MODE_TICK: begin
              res_ok_r <= 1'b1;
              tg_r     <= 2'd0;
              state_r  <= S_TICK;
            end
            default: begin
              // restore: sweep all joints with the current direction
              res_ok_r   <= 1'b1;
              sweep_r    <= 1'b1;
              sweep_cw_r <= clockwise_r;
              sidx_r     <= '0;
              state_r    <= S_SWEEP;
            end
          endcase
        end

        S_SWEEP: begin
          n_r       <= n_calc;
          map_idx_r <= sidx_r;
          state_r   <= S_MAP_Q;
        end

        S_MAP_Q: begin
          q0_r    <= recip_prod[RECIP_SH+9:RECIP_SH];
          state_r <= S_MAP_FIX;
        end

        S_MAP_FIX: begin
          if (sweep_r) begin
            if (sidx_r == JOINT_LAST) begin
              sweep_r <= 1'b0;
              init_r  <= 1'b0;
              state_r <= init_r ? S_IDLE : S_DONE;
            end else begin
              sidx_r  <= sidx_r + 1'b1;
              state_r <= S_SWEEP;
            end
          end else begin
            state_r <= S_DONE;
          end
        end

        S_TICK: begin
          // one group read per cycle; data of the previous read lands now
          tv_r <= tick_valid;
          case (tg_r)
            2'd1:    res_p0_r <= tv_r ? pw_rdata : 10'd0;
            2'd2:    res_p1_r <= tv_r ? pw_rdata : 10'd0;
            2'd3:    res_p2_r <= tv_r ? pw_rdata : 10'd0;
            default: ;
          endcase
          if (tg_r == 2'd3) begin
            res_mux_r   <= ls_r;
            res_frame_r <= (la_nxt == 3'd0);
            ls_r        <= ls_nxt;
            la_r        <= la_nxt;
            state_r     <= S_DONE;
          end else begin
            tg_r <= tg_r + 2'd1;
          end
        end

        S_DONE: begin
          if (out_load) begin
            out_ok_r    <= res_ok_r;
            out_low_r   <= res_low_r;
            out_high_r  <= res_high_r;
            out_home_r  <= res_home_r;
            out_mux_r   <= res_mux_r;
            out_p0_r    <= res_p0_r;
            out_p1_r    <= res_p1_r;
            out_p2_r    <= res_p2_r;
            out_frame_r <= res_frame_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_low_limit    = out_low_r;
  assign out_high_limit   = out_high_r;
  assign out_home_angle   = out_home_r;
  assign out_mux_line     = out_mux_r;
  assign out_pulse_group0 = out_p0_r;
  assign out_pulse_group1 = out_p1_r;
  assign out_pulse_group2 = out_p2_r;
  assign out_frame_done   = out_frame_r;

endmodule

`default_nettype wire

>>> rtl/sjlm_ram.sv
// ----------------------------------------------------------------------------
// sjlm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> tb/tb_servo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_pkg
// Result word type and scoreboard for the servo joint limit and PWM mux
// block. The scoreboard keeps its own joint table, predicts the result word
// of every accepted command and checks the words the block returns in order.
// ----------------------------------------------------------------------------
package tb_servo_pkg;

  localparam int JOINTS         = 24;
  localparam int MUX            = 8;
  localparam int ANGLE_LO_BOUND = -800;
  localparam int ANGLE_HI_BOUND = 800;
  localparam int PULSE_MIN      = 492;
  localparam int PULSE_MAX      = 816;

  localparam int FACTORY_HOME [JOINTS] = '{
    -40, 245, 470, -100, -205, 50, 445, 245, -75, 0, 0, 0,
    15, -70, -390, 250, 195, -105, -510, -305, 60, 0, 0, 0
  };

  typedef struct packed {
    logic                ok;
    logic signed [15:0]  low_limit;
    logic signed [15:0]  high_limit;
    logic signed [15:0]  home_angle;
    logic [2:0]          mux_line;
    logic [9:0]          pulse0;
    logic [9:0]          pulse1;
    logic [9:0]          pulse2;
    logic                frame_done;
  } servo_result_t;

  class joint_table_scoreboard;
    int            lo_lim [JOINTS];
    int            hi_lim [JOINTS];
    int            home [JOINTS];
    logic [9:0]    pulse [JOINTS];
    int            line_sel;
    int            lookahead;
    logic          cw;
    servo_result_t awaited_results [$];
    int            errors;
    int            mode_count [8];
    int            rejected;
    int            frames;

    function new();
      cw        = 1'b1;
      line_sel  = 0;
      lookahead = 1 % MUX;
      errors    = 0;
      rejected  = 0;
      frames    = 0;
      foreach (mode_count[m]) mode_count[m] = 0;
      reload_defaults();
    endfunction

    function void set_clockwise(logic v);
      cw = v;
    endfunction

    function logic [9:0] angle_to_pulse(int a);
      int lo;
      int hi;
      int p;
      lo = cw ? PULSE_MIN : PULSE_MAX;
      hi = cw ? PULSE_MAX : PULSE_MIN;
      // integer division truncates toward zero
      p = (a - ANGLE_LO_BOUND) * (hi - lo) / (ANGLE_HI_BOUND - ANGLE_LO_BOUND) + lo;
      return p[9:0];
    endfunction

    function void move_joint(int j, int a);
      if (a < lo_lim[j]) a = lo_lim[j];
      if (a > hi_lim[j]) a = hi_lim[j];
      pulse[j] = angle_to_pulse(a);
    endfunction

    function void reload_defaults();
      for (int j = 0; j < JOINTS; j++) begin
        lo_lim[j] = ANGLE_LO_BOUND;
        hi_lim[j] = ANGLE_HI_BOUND;
        home[j]   = FACTORY_HOME[j];
        move_joint(j, home[j]);
      end
    endfunction

    function servo_result_t apply_command(logic [2:0] mode, logic [4:0] joint,
                                          logic signed [15:0] angle);
      servo_result_t r;
      logic [9:0]    pw [3];
      int            j;
      int            a;
      int            idx;
      logic          known;
      r     = '0;
      j     = joint;
      a     = angle;
      known = j < JOINTS;
      case (mode)
        sjlm_pkg::MODE_SET_ANGLE: begin
          if (known) begin
            move_joint(j, a);
            r.ok = 1'b1;
          end
        end
        sjlm_pkg::MODE_SET_OFFSET: begin
          // sum is formed wide, then clamped
          if (known) begin
            move_joint(j, a + home[j]);
            r.ok = 1'b1;
          end
        end
        sjlm_pkg::MODE_SET_LOW: begin
          if (known && a < hi_lim[j] && a >= ANGLE_LO_BOUND) begin
            lo_lim[j] = a;
            r.ok = 1'b1;
          end
        end
        sjlm_pkg::MODE_SET_HIGH: begin
          if (known && a > lo_lim[j] && a <= ANGLE_HI_BOUND) begin
            hi_lim[j] = a;
            r.ok = 1'b1;
          end
        end
        sjlm_pkg::MODE_SET_HOME: begin
          if (known && a >= lo_lim[j] && a <= hi_lim[j]) begin
            home[j] = a;
            r.ok = 1'b1;
          end
        end
        sjlm_pkg::MODE_READ: begin
          if (known) begin
            r.ok         = 1'b1;
            r.low_limit  = 16'(lo_lim[j]);
            r.high_limit = 16'(hi_lim[j]);
            r.home_angle = 16'(home[j]);
          end else begin
            r.low_limit  = sjlm_pkg::BAD_READ;
            r.high_limit = sjlm_pkg::BAD_READ;
            r.home_angle = sjlm_pkg::BAD_READ;
          end
        end
        sjlm_pkg::MODE_TICK: begin
          r.ok       = 1'b1;
          r.mux_line = 3'(line_sel);
          for (int g = 0; g < 3; g++) begin
            idx   = lookahead + g * MUX;
            pw[g] = (idx < JOINTS) ? pulse[idx] : 10'd0;
          end
          r.pulse0     = pw[0];
          r.pulse1     = pw[1];
          r.pulse2     = pw[2];
          line_sel     = (line_sel + 1) % MUX;
          lookahead    = (lookahead + 1) % MUX;
          r.frame_done = (lookahead == 0);
          if (r.frame_done) frames++;
        end
        default: begin
          // restore defaults
          reload_defaults();
          r.ok = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_command(logic [2:0] mode, logic [4:0] joint,
                               logic signed [15:0] angle);
      servo_result_t r;
      r = apply_command(mode, joint, angle);
      mode_count[mode]++;
      if (!r.ok) rejected++;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result word with no command pending", $time);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("low_limit", want.low_limit, got.low_limit);
      compare_field("high_limit", want.high_limit, got.high_limit);
      compare_field("home_angle", want.home_angle, got.home_angle);
      compare_field("mux_line", want.mux_line, got.mux_line);
      compare_field("pulse_group0", want.pulse0, got.pulse0);
      compare_field("pulse_group1", want.pulse1, got.pulse1);
      compare_field("pulse_group2", want.pulse2, got.pulse2);
      compare_field("frame_done", want.frame_done, got.frame_done);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of servo_joint_limit_and_mux_pwm. Directed commands cover the
// field extremes, limit validation and bad joints; then random commands and
// per-joint limit/home/angle sequences run under both direction settings,
// with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 215;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode     = '0;
  logic [4:0]         in_joint    = '0;
  logic signed [15:0] in_angle    = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic               out_ok;
  logic signed [15:0] out_low_limit;
  logic signed [15:0] out_high_limit;
  logic signed [15:0] out_home_angle;
  logic [2:0]         out_mux_line;
  logic [9:0]         out_pulse_group0;
  logic [9:0]         out_pulse_group1;
  logic [9:0]         out_pulse_group2;
  logic               out_frame_done;

  logic idle_on     = 1'b1;
  logic hold_req    = 1'b0;
  int   hold_cycles = 0;
  int   cycle_count = 0;
  int   words_sent  = 0;

  tb_servo_pkg::joint_table_scoreboard sb = new();

  servo_joint_limit_and_mux_pwm i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_joint         (in_joint),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_low_limit    (out_low_limit),
    .out_high_limit   (out_high_limit),
    .out_home_angle   (out_home_angle),
    .out_mux_line     (out_mux_line),
    .out_pulse_group0 (out_pulse_group0),
    .out_pulse_group1 (out_pulse_group1),
    .out_pulse_group2 (out_pulse_group2),
    .out_frame_done   (out_frame_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Observe both channels and the config port at each edge.
  always @(posedge clk) begin : monitor
    tb_servo_pkg::servo_result_t got;
    if (rst_n) begin
      if (cfg_wr_en) sb.set_clockwise(cfg_wr_data);
      if (out_valid && !out_stall) begin
        got.ok         = out_ok;
        got.low_limit  = out_low_limit;
        got.high_limit = out_high_limit;
        got.home_angle = out_home_angle;
        got.mux_line   = out_mux_line;
        got.pulse0     = out_pulse_group0;
        got.pulse1     = out_pulse_group1;
        got.pulse2     = out_pulse_group2;
        got.frame_done = out_frame_done;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) sb.note_command(in_mode, in_joint, in_angle);
    end
  end

  // Result side: one long hold-off on request, otherwise short random stalls.
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 3)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [2:0] mode, input logic [4:0] joint,
                           input logic signed [15:0] angle);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_joint <= joint;
    in_angle <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_clockwise(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_angle();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = tb_servo_pkg::ANGLE_LO_BOUND;
          3: v = tb_servo_pkg::ANGLE_HI_BOUND;
          4: v = tb_servo_pkg::ANGLE_LO_BOUND - 1;
          default: v = tb_servo_pkg::ANGLE_HI_BOUND + 1;
        endcase
      end
      default: v = int'($urandom_range(0, 1800)) - 900;
    endcase
    return 16'(v);
  endfunction

  function automatic logic [4:0] random_joint();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(tb_servo_pkg::JOINTS, 31));
    return 5'($urandom_range(0, tb_servo_pkg::JOINTS - 1));
  endfunction

  function automatic sjlm_pkg::mode_t random_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return sjlm_pkg::MODE_SET_ANGLE;
    if (r < 40) return sjlm_pkg::MODE_SET_OFFSET;
    if (r < 50) return sjlm_pkg::MODE_SET_LOW;
    if (r < 60) return sjlm_pkg::MODE_SET_HIGH;
    if (r < 70) return sjlm_pkg::MODE_SET_HOME;
    if (r < 82) return sjlm_pkg::MODE_READ;
    if (r < 97) return sjlm_pkg::MODE_TICK;
    return sjlm_pkg::MODE_RESTORE;
  endfunction

  // Narrow one joint's window, move it around inside and outside, read back.
  task automatic run_joint_recipe();
    logic [4:0] j;
    int         lo;
    int         hi;
    j  = 5'($urandom_range(0, tb_servo_pkg::JOINTS - 1));
    lo = int'($urandom_range(0, 1500)) + tb_servo_pkg::ANGLE_LO_BOUND;
    hi = lo + 1 + int'($urandom_range(0, tb_servo_pkg::ANGLE_HI_BOUND - lo - 1));
    send_word(sjlm_pkg::MODE_SET_HIGH, j, 16'(tb_servo_pkg::ANGLE_HI_BOUND));
    send_word(sjlm_pkg::MODE_SET_LOW, j, 16'(lo));
    send_word(sjlm_pkg::MODE_SET_HIGH, j, 16'(hi));
    send_word(sjlm_pkg::MODE_SET_HOME, j, 16'(lo + int'($urandom_range(0, hi - lo))));
    repeat ($urandom_range(2, 5))
      send_word($urandom_range(0, 1) ? sjlm_pkg::MODE_SET_ANGLE : sjlm_pkg::MODE_SET_OFFSET,
                j, random_angle());
    if ($urandom_range(0, 1)) send_word(sjlm_pkg::MODE_TICK, random_joint(), random_angle());
    send_word(sjlm_pkg::MODE_READ, j, random_angle());
  endtask

  initial begin
    int phase_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents, bad joints and a full look-ahead frame
    send_word(sjlm_pkg::MODE_READ, 5'd0, 16'sd0);
    send_word(sjlm_pkg::MODE_READ, 5'd23, 16'sd0);
    send_word(sjlm_pkg::MODE_READ, 5'd24, 16'sd0);
    send_word(sjlm_pkg::MODE_READ, 5'd31, -16'sd1);
    repeat (8) send_word(sjlm_pkg::MODE_TICK, 5'd31, 16'sh7fff);
    // clamp at both ends, wide offset sums
    send_word(sjlm_pkg::MODE_SET_ANGLE, 5'd0, 16'sh7fff);
    send_word(sjlm_pkg::MODE_SET_ANGLE, 5'd1, 16'sh8000);
    send_word(sjlm_pkg::MODE_SET_ANGLE, 5'd24, 16'sd0);
    send_word(sjlm_pkg::MODE_SET_OFFSET, 5'd2, 16'sh7fff);
    send_word(sjlm_pkg::MODE_SET_OFFSET, 5'd3, 16'sh8000);
    // limit and home validation edges
    send_word(sjlm_pkg::MODE_SET_LOW, 5'd4, 16'(tb_servo_pkg::ANGLE_LO_BOUND - 1));
    send_word(sjlm_pkg::MODE_SET_LOW, 5'd4, 16'(tb_servo_pkg::ANGLE_HI_BOUND));
    send_word(sjlm_pkg::MODE_SET_LOW, 5'd4, -16'sd200);
    send_word(sjlm_pkg::MODE_SET_HIGH, 5'd4, -16'sd200);
    send_word(sjlm_pkg::MODE_SET_HIGH, 5'd4, 16'(tb_servo_pkg::ANGLE_HI_BOUND + 1));
    send_word(sjlm_pkg::MODE_SET_HIGH, 5'd4, 16'sd300);
    send_word(sjlm_pkg::MODE_SET_HOME, 5'd4, -16'sd201);
    send_word(sjlm_pkg::MODE_SET_HOME, 5'd4, 16'sd300);
    send_word(sjlm_pkg::MODE_SET_HOME, 5'd31, 16'sd0);
    send_word(sjlm_pkg::MODE_SET_ANGLE, 5'd4, 16'sh8000);
    send_word(sjlm_pkg::MODE_READ, 5'd4, 16'sd0);
    send_word(sjlm_pkg::MODE_RESTORE, 5'd31, 16'sh7fff);
    send_word(sjlm_pkg::MODE_READ, 5'd4, 16'sd0);
    repeat (3) send_word(sjlm_pkg::MODE_TICK, 5'd0, 16'sd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_results_drained();
      write_clockwise(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      if (p == 0) send_word(sjlm_pkg::MODE_RESTORE, 5'd0, 16'sd0);
      if (p == 2) begin
        hold_cycles = 300;
        hold_req    = 1'b1;
      end
      // quiet finish: no idling on either side
      if (p == PHASES - 1) idle_on = 1'b0;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 3) == 0) run_joint_recipe();
        else send_word(random_mode(), random_joint(), random_angle());
      end
    end

    wait_results_drained();
    repeat (100) @(posedge clk);
    $display("%0d commands checked: %0d ticks, %0d restores, %0d rejected, %0d frame wraps",
             words_sent, sb.mode_count[sjlm_pkg::MODE_TICK],
             sb.mode_count[sjlm_pkg::MODE_RESTORE], sb.rejected, sb.frames);
    $display("both pulse directions, bad joints, limit edges, long output hold-off covered");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d field mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sjlm_pkg.sv
rtl/sjlm_ram.sv
rtl/servo_joint_limit_and_mux_pwm.sv
tb/tb_servo_pkg.sv
tb/tb.sv
